// File: rtl/core/llmb_pkg.sv
// shared constants, codes and types of the fully connected layer core
package llmb_pkg;

  localparam int MAX_ROWS  = 16;
  localparam int MAX_INNER = 16;
  localparam int MAX_OUT   = 16;

  localparam int IN_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int W_DEPTH  = MAX_OUT * MAX_INNER;
  localparam int IN_AW    = $clog2(IN_DEPTH);
  localparam int W_AW     = $clog2(W_DEPTH);
  localparam int B_AW     = $clog2(MAX_OUT);

  localparam int CNT_W    = 5;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 5;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 40;

  typedef enum logic [1:0] {
    CMD_LOAD_IN   = 2'd0,
    CMD_LOAD_W    = 2'd1,
    CMD_LOAD_BIAS = 2'd2,
    CMD_COMPUTE   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_NUM_ROWS    = 2'd0,
    CFG_INNER_LEN   = 2'd1,
    CFG_OUT_LEN     = 2'd2,
    CFG_BIAS_ENABLE = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

endpackage

// File: rtl/core/llmb_stream_if.sv
// command and result channel interfaces
interface llmb_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [3:0]         row;
  logic [3:0]         col;
  logic signed [15:0] value;

  modport source (output valid, cmd, row, col, value, input ready);
  modport sink (input valid, cmd, row, col, value, output ready);
endinterface

interface llmb_rsp_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_row;
  logic [3:0]         out_col;
  logic signed [39:0] out_value;
  logic               last;

  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

// File: rtl/core/linear_layer_matmul_bias_core.sv
// top level of the fully connected layer core: stores, sequencer and result register
// Load commands (input, weight, bias element) are accepted while the core is idle.
// A compute-row command streams inner_len products per output column through one
// multiply-accumulate unit fed by one read port of each store, then does the bias
// add and result hand-off, waiting while the result channel stalls. Results come
// one word per column in column order, the final one flagged by last. The last
// result may still wait in the output register while the next command is taken.
module linear_layer_matmul_bias_core
  import llmb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  llmb_req_if.sink          req,
  llmb_rsp_if.source        rsp
);

  logic [CNT_W-1:0] num_rows;
  logic [CNT_W-1:0] inner_len;
  logic [CNT_W-1:0] out_len;
  logic             bias_enable;

  logic [CNT_W-1:0] m_lim;
  logic [CNT_W-1:0] n_lim;
  logic [CNT_W-1:0] k_lim;

  logic [ELEM_W-1:0] input_mem  [IN_DEPTH];
  logic [ELEM_W-1:0] weight_mem [W_DEPTH];
  logic [ELEM_W-1:0] bias_mem   [MAX_OUT];

  logic signed [ELEM_W-1:0] in_q;
  logic signed [ELEM_W-1:0] w_q;
  logic signed [ELEM_W-1:0] bias_q;

  state_t           state;
  state_t           state_next;
  logic [3:0]       row_q;
  logic [CNT_W-1:0] t;
  logic [CNT_W-1:0] j;
  logic             rd_v;

  logic             accept;
  logic             start;
  logic             rd_en;
  logic             fin_fire;
  logic             col_last;
  logic             mac_busy;
  mac_ctrl_t        mac_ctrl;
  logic signed [ACC_W-1:0] acc;
  logic [IN_AW-1:0] in_rd_addr;
  logic [W_AW-1:0]  w_rd_addr;

  logic               out_valid;
  logic [3:0]         out_row;
  logic [3:0]         out_col;
  logic signed [39:0] out_value;
  logic               out_last;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows    <= CNT_W'(MAX_ROWS);
      inner_len   <= CNT_W'(MAX_INNER);
      out_len     <= CNT_W'(MAX_OUT);
      bias_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NUM_ROWS:    num_rows    <= cfg_data;
        CFG_INNER_LEN:   inner_len   <= cfg_data;
        CFG_OUT_LEN:     out_len     <= cfg_data;
        CFG_BIAS_ENABLE: bias_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign m_lim = (int'(num_rows) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : num_rows;
  assign n_lim = (int'(inner_len) > MAX_INNER) ? CNT_W'(MAX_INNER) : inner_len;
  assign k_lim = (int'(out_len) > MAX_OUT) ? CNT_W'(MAX_OUT) : out_len;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign start     = accept && (cmd_t'(req.cmd) == CMD_COMPUTE) &&
                     (int'(req.row) < int'(m_lim)) && (k_lim != '0);

  // stores
  always_ff @(posedge clk) begin
    if (accept && cmd_t'(req.cmd) == CMD_LOAD_IN &&
        int'(req.row) < MAX_ROWS && int'(req.col) < MAX_INNER) begin
      input_mem[IN_AW'(int'(req.row) * MAX_INNER + int'(req.col))] <= req.value;
    end
    if (rd_en) begin
      in_q <= input_mem[in_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd_t'(req.cmd) == CMD_LOAD_W &&
        int'(req.row) < MAX_OUT && int'(req.col) < MAX_INNER) begin
      weight_mem[W_AW'(int'(req.row) * MAX_INNER + int'(req.col))] <= req.value;
    end
    if (rd_en) begin
      w_q <= weight_mem[w_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd_t'(req.cmd) == CMD_LOAD_BIAS && int'(req.col) < MAX_OUT) begin
      bias_mem[B_AW'(req.col)] <= req.value;
    end
    bias_q <= bias_mem[j[B_AW-1:0]];
  end

  assign in_rd_addr = IN_AW'(int'(row_q) * MAX_INNER + int'(t));
  assign w_rd_addr  = W_AW'(int'(j) * MAX_INNER + int'(t));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_v  <= 1'b0;
      t     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      rd_v  <= rd_en;
      if (start) begin
        t <= '0;
        j <= '0;
      end else if (rd_en) begin
        t <= t + 1'b1;
      end else if (fin_fire) begin
        t <= '0;
        j <= j + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      row_q <= req.row;
    end
  end

  assign col_last = ((j + 1'b1) == k_lim);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_MAC;
      ST_MAC:  if (t == n_lim && !rd_v && !mac_busy) state_next = ST_FIN;
      ST_FIN: begin
        if (!out_valid || rsp.ready) begin
          state_next = col_last ? ST_IDLE : ST_MAC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en    = 1'b0;
    fin_fire = 1'b0;
    case (state)
      ST_MAC:  rd_en    = (t < n_lim);
      ST_FIN:  fin_fire = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  assign mac_ctrl.clr = start || fin_fire;
  assign mac_ctrl.vld = rd_v;

  llmb_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a    (in_q),
    .b    (w_q),
    .acc  (acc),
    .busy (mac_busy)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_row   <= row_q;
      out_col   <= j[3:0];
      out_last  <= col_last;
      out_value <= bias_enable
                 ? acc + {{(ACC_W-ELEM_W-8){bias_q[ELEM_W-1]}}, bias_q, 8'b0}
                 : acc;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.out_row   = out_row;
  assign rsp.out_col   = out_col;
  assign rsp.out_value = out_value;
  assign rsp.last      = out_last;

endmodule

// File: rtl/core/llmb_mac.sv
// multiply-accumulate unit with registered product and 40-bit accumulator
module llmb_mac
  import llmb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctrl_t                ctrl,
  input  logic signed [ELEM_W-1:0] a,
  input  logic signed [ELEM_W-1:0] b,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     busy
);

  logic                     prod_v;
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (rst) begin
      prod_v <= 1'b0;
      acc    <= '0;
    end else begin
      prod_v <= ctrl.vld;
      if (ctrl.clr) begin
        acc <= '0;
      end else if (prod_v) begin
        acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      end
    end
  end

  assign busy = prod_v;

endmodule
